>>> rtl/record_field_layout_assert.svh
// ---------------------------------------------------------------------------
// record_field_layout assertion macros
// Concurrent check wrappers used by the record layout engine (rfl_back).
// ---------------------------------------------------------------------------
`ifndef RECORD_FIELD_LAYOUT_ASSERT_SVH
`define RECORD_FIELD_LAYOUT_ASSERT_SVH

`ifndef ASSERT_OFF

// ante true at an edge: cons must hold at that edge
`define RFL_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// ante true at an edge: cons must hold at the next edge
`define RFL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// expr must never hold
`define RFL_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");

`else

`define RFL_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RFL_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`define RFL_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

>>> rtl/rfl_pkg.sv
// ---------------------------------------------------------------------------
// rfl_pkg
// Field widths, member classes and word types of the record layout block.
// ---------------------------------------------------------------------------
`default_nettype none

package rfl_pkg;

    localparam int SIZE_W    = 16;
    localparam int ALIGN_W   = 13;
    localparam int BITW_W    = 8;
    localparam int OUT_OFS_W = 24;
    localparam int BITOFF_W  = 7;
    localparam int APB_DW    = 32;

    localparam logic [ALIGN_W-1:0] ALIGN_MAX = 13'd4096;
    localparam logic [BITW_W-1:0]  BITW_MAX  = 8'd128;
    // a storage unit of 16 bytes or more holds the full 128 bits
    localparam logic [SIZE_W-1:0]  UNIT_FULL_BYTES = 16'd16;

    // register index, decoded from paddr[2]
    localparam logic REG_UNION_MODE = 1'b0;

    typedef enum logic [1:0] {
        CLS_BITFIELD,
        CLS_SEPARATOR,
        CLS_ORDINARY
    } t_cls;

    // normalized member word, front to back
    typedef struct packed {
        logic [SIZE_W-1:0]  size;
        logic [ALIGN_W-1:0] align;
        logic [BITW_W-1:0]  width;
        t_cls               cls;
        logic               union_mode;
        logic               last;
    } t_item;

    // result word
    typedef struct packed {
        logic [OUT_OFS_W-1:0] field_offset;
        logic [BITOFF_W-1:0]  field_bit_offset;
        logic [OUT_OFS_W-1:0] record_size;
        logic [ALIGN_W-1:0]   record_align;
        logic                 record_done;
        logic                 overflow;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/rfl_front.sv
// ---------------------------------------------------------------------------
// rfl_front
// Normalizes alignment and bit width of a member and classifies it.
// ---------------------------------------------------------------------------
`default_nettype none

module rfl_front import rfl_pkg::*; (
    input  wire logic [SIZE_W-1:0]  i_member_size,
    input  wire logic [ALIGN_W-1:0] i_member_align,
    input  wire logic [BITW_W-1:0]  i_bit_width,
    input  wire logic               i_is_named,
    input  wire logic               i_is_aggregate,
    input  wire logic               i_last_member,
    input  wire logic               i_union_mode,
    output t_item                   o_item
);

    logic [ALIGN_W-1:0] align_lim;
    logic [ALIGN_W-1:0] align_pow;

    always_comb begin
        if (i_member_align == '0) begin
            align_lim = 13'd1;
        end else if (i_member_align > ALIGN_MAX) begin
            align_lim = ALIGN_MAX;
        end else begin
            align_lim = i_member_align;
        end
        // pick the smallest power of two not below the request
        align_pow = ALIGN_MAX;
        for (int k = ALIGN_W - 1; k >= 0; k--) begin
            if ((13'd1 << k) >= align_lim) begin
                align_pow = 13'd1 << k;
            end
        end
    end

    always_comb begin
        o_item.size       = i_member_size;
        o_item.align      = align_pow;
        o_item.width      = (i_bit_width > BITW_MAX) ? BITW_MAX : i_bit_width;
        o_item.union_mode = i_union_mode;
        o_item.last       = i_last_member;
        priority if (i_bit_width != '0) begin
            o_item.cls = CLS_BITFIELD;
        end else if (!i_is_named && !i_is_aggregate) begin
            o_item.cls = CLS_SEPARATOR;
        end else begin
            o_item.cls = CLS_ORDINARY;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rfl_queue.sv
// ---------------------------------------------------------------------------
// rfl_queue
// Small register queue with valid/ready on both sides.
// ---------------------------------------------------------------------------
`default_nettype none

module rfl_queue #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr_valid,
    output logic      o_wr_ready,
    input  T          i_wr_data,
    output logic      o_rd_valid,
    input  wire logic i_rd_ready,
    output T          o_rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW:0] CNT_FULL = (AW+1)'(DEPTH);

    T              r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [AW:0]   r_count, n_count;
    logic          wr_fire, rd_fire;

    assign o_wr_ready = (r_count != CNT_FULL);
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign wr_fire    = i_wr_valid && o_wr_ready;
    assign rd_fire    = o_rd_valid && i_rd_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_fire) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_fire) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({wr_fire, rd_fire})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rfl_back.sv
// ---------------------------------------------------------------------------
// rfl_back
// Layout engine: updates the running offset and bit position per member,
// then forms the record total and queues the result word.
// ---------------------------------------------------------------------------
`default_nettype none
`include "record_field_layout_assert.svh"

module rfl_back import rfl_pkg::*; #(
    parameter int RO_W = 24
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_item     i_item,
    input  wire logic i_item_valid,
    output logic      o_item_ready,
    output t_result   o_res,
    output logic      o_res_valid,
    input  wire logic i_res_ready
);

    localparam int CW = (RO_W > SIZE_W) ? RO_W + 2 : SIZE_W + 2;
    localparam logic [CW-1:0] LIM = CW'((64'd1 << RO_W) - 64'd1);

    typedef struct packed {
        logic [RO_W-1:0]    fo;
        logic [BITW_W-1:0]  bo;
        logic               last;
        logic               union_mode;
        logic [RO_W-1:0]    ro;
        logic [BITW_W-1:0]  bp;
        logic [ALIGN_W-1:0] la;
        logic [SIZE_W-1:0]  ls;
        logic               ovf;
    } t_stage;

    function automatic logic [CW-1:0] round_up(input logic [CW-1:0] v,
                                               input logic [ALIGN_W-1:0] al);
        logic [CW-1:0] m;
        m = CW'(al - 13'd1);
        return (v + m) & ~m;
    endfunction

    // saturate to the offset limit, flag in the top bit
    function automatic logic [RO_W:0] sat(input logic [CW-1:0] v);
        logic [RO_W:0] res;
        if (v > LIM) begin
            res = {1'b1, LIM[RO_W-1:0]};
        end else begin
            res = {1'b0, v[RO_W-1:0]};
        end
        return res;
    endfunction

    // whole bytes touched by a partial unit
    function automatic logic [BITW_W-3:0] used_bytes(input logic [BITW_W-1:0] bp);
        logic [BITW_W:0] s;
        s = {1'b0, bp} + 9'd7;
        return s[BITW_W:3];
    endfunction

    // layout state
    logic [RO_W-1:0]    r_running_offset, n_running_offset;
    logic [BITW_W-1:0]  r_bit_position,   n_bit_position;
    logic [SIZE_W-1:0]  r_unit_bytes,     n_unit_bytes;
    logic [ALIGN_W-1:0] r_largest_align,  n_largest_align;
    logic [SIZE_W-1:0]  r_largest_size,   n_largest_size;
    logic               r_overflow_seen,  n_overflow_seen;

    t_stage r_b;
    logic   r_b_valid, n_b_valid;

    logic a_fire, b_fire, out_wr_ready;

    // updated values before the end-of-record clear
    logic [RO_W-1:0]    up_ro;
    logic [BITW_W-1:0]  up_bp;
    logic [SIZE_W-1:0]  up_ub;
    logic [ALIGN_W-1:0] up_la;
    logic [SIZE_W-1:0]  up_ls;
    logic               up_ovf;
    logic [RO_W-1:0]    fo;
    logic [BITW_W-1:0]  bo;

    logic [RO_W:0]      s_a, s_b;
    logic [RO_W-1:0]    ro1, ro2;
    logic [SIZE_W-1:0]  ub1, ub2;
    logic [BITW_W-1:0]  bp2;
    logic [BITW_W-1:0]  ub_bits;

    assign o_item_ready = !r_b_valid || out_wr_ready;
    assign a_fire       = i_item_valid && o_item_ready;
    assign b_fire       = r_b_valid && out_wr_ready;

    always_comb begin
        up_la  = (i_item.align > r_largest_align) ? i_item.align : r_largest_align;
        up_ls  = (i_item.size > r_largest_size) ? i_item.size : r_largest_size;
        up_ro  = r_running_offset;
        up_bp  = r_bit_position;
        up_ub  = r_unit_bytes;
        up_ovf = r_overflow_seen;
        fo     = '0;
        bo     = '0;
        s_a    = '0;
        s_b    = '0;
        ro1    = r_running_offset;
        ro2    = r_running_offset;
        ub1    = r_unit_bytes;
        ub2    = r_unit_bytes;
        bp2    = r_bit_position;
        ub_bits = '0;
        if (!i_item.union_mode) begin
            unique case (i_item.cls)
                CLS_BITFIELD: begin
                    if (r_bit_position == '0) begin
                        s_a = sat(round_up(CW'(r_running_offset), i_item.align));
                        ro1 = s_a[RO_W-1:0];
                        ub1 = i_item.size;
                    end else begin
                        ro1 = r_running_offset;
                        ub1 = (i_item.size > r_unit_bytes) ? i_item.size : r_unit_bytes;
                    end
                    ub_bits = (ub1 >= UNIT_FULL_BYTES) ? BITW_MAX : {1'b0, ub1[3:0], 3'b000};
                    // no room left: close the unit and open a new one
                    if (({1'b0, r_bit_position} + {1'b0, i_item.width}) >
                        {1'b0, ub_bits}) begin
                        s_b = sat(round_up(CW'(ro1) + CW'(ub1), i_item.align));
                        ro2 = s_b[RO_W-1:0];
                        bp2 = '0;
                        ub2 = i_item.size;
                    end else begin
                        ro2 = ro1;
                        bp2 = r_bit_position;
                        ub2 = ub1;
                    end
                    fo     = ro2;
                    bo     = bp2;
                    up_ro  = ro2;
                    up_bp  = bp2 + i_item.width;
                    up_ub  = ub2;
                    up_ovf = r_overflow_seen | s_a[RO_W] | s_b[RO_W];
                end
                CLS_SEPARATOR: begin
                    if (r_bit_position != '0) begin
                        s_a   = sat(CW'(r_running_offset) + CW'(r_unit_bytes));
                        up_ro = s_a[RO_W-1:0];
                        up_bp = '0;
                    end
                    fo     = up_ro;
                    up_ovf = r_overflow_seen | s_a[RO_W];
                end
                CLS_ORDINARY: begin
                    s_a = sat(round_up(CW'(r_running_offset) +
                                       CW'(used_bytes(r_bit_position)), i_item.align));
                    fo  = s_a[RO_W-1:0];
                    s_b = sat(CW'(s_a[RO_W-1:0]) + CW'(i_item.size));
                    up_ro  = s_b[RO_W-1:0];
                    up_bp  = '0;
                    up_ovf = r_overflow_seen | s_a[RO_W] | s_b[RO_W];
                end
            endcase
        end
    end

    always_comb begin
        n_running_offset = r_running_offset;
        n_bit_position   = r_bit_position;
        n_unit_bytes     = r_unit_bytes;
        n_largest_align  = r_largest_align;
        n_largest_size   = r_largest_size;
        n_overflow_seen  = r_overflow_seen;
        if (a_fire) begin
            if (i_item.last) begin
                // record closed: drop back to the empty layout
                n_running_offset = '0;
                n_bit_position   = '0;
                n_unit_bytes     = '0;
                n_largest_align  = 13'd1;
                n_largest_size   = '0;
                n_overflow_seen  = 1'b0;
            end else begin
                n_running_offset = up_ro;
                n_bit_position   = up_bp;
                n_unit_bytes     = up_ub;
                n_largest_align  = up_la;
                n_largest_size   = up_ls;
                n_overflow_seen  = up_ovf;
            end
        end
        n_b_valid = a_fire || (r_b_valid && !b_fire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_offset <= '0;
            r_bit_position   <= '0;
            r_unit_bytes     <= '0;
            r_largest_align  <= 13'd1;
            r_largest_size   <= '0;
            r_overflow_seen  <= 1'b0;
            r_b_valid        <= 1'b0;
        end else begin
            r_running_offset <= n_running_offset;
            r_bit_position   <= n_bit_position;
            r_unit_bytes     <= n_unit_bytes;
            r_largest_align  <= n_largest_align;
            r_largest_size   <= n_largest_size;
            r_overflow_seen  <= n_overflow_seen;
            r_b_valid        <= n_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_b.fo         <= fo;
            r_b.bo         <= bo;
            r_b.last       <= i_item.last;
            r_b.union_mode <= i_item.union_mode;
            r_b.ro         <= up_ro;
            r_b.bp         <= up_bp;
            r_b.la         <= up_la;
            r_b.ls         <= up_ls;
            r_b.ovf        <= up_ovf;
        end
    end

    // record total on the last member
    logic [CW-1:0] pre_total;
    logic [RO_W:0] s_total;
    t_result       res;

    always_comb begin
        if (r_b.union_mode) begin
            pre_total = CW'(r_b.ls);
        end else begin
            pre_total = CW'(r_b.ro) + CW'(used_bytes(r_b.bp));
        end
        s_total = sat(round_up(pre_total, r_b.la));
        res.field_offset     = OUT_OFS_W'(r_b.fo);
        res.field_bit_offset = r_b.bo[BITOFF_W-1:0];
        res.record_size      = r_b.last ? OUT_OFS_W'(s_total[RO_W-1:0]) : '0;
        res.record_align     = r_b.last ? r_b.la : 13'd1;
        res.record_done      = r_b.last;
        res.overflow         = r_b.ovf | (r_b.last & s_total[RO_W]);
    end

    rfl_queue #(
        .T     (t_result),
        .DEPTH (2)
    ) u_out_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (r_b_valid),
        .o_wr_ready (out_wr_ready),
        .i_wr_data  (res),
        .o_rd_valid (o_res_valid),
        .i_rd_ready (i_res_ready),
        .o_rd_data  (o_res)
    );

    `RFL_ASSERT_NEXT(a_last_clears_state, i_clk, i_rst_n, a_fire && i_item.last,
        r_running_offset == '0 && r_bit_position == '0 && r_largest_align == 13'd1 && !r_overflow_seen)
    `RFL_ASSERT_NEVER(a_bit_position_bound, i_clk, i_rst_n, r_bit_position > BITW_MAX)
    `RFL_ASSERT_IMPL(a_union_offset_zero, i_clk, i_rst_n, r_b_valid && r_b.union_mode,
        r_b.fo == '0 && r_b.bo == '0)
    `RFL_ASSERT_NEXT(a_overflow_sticky, i_clk, i_rst_n, r_overflow_seen && !(a_fire && i_item.last),
        r_overflow_seen)

endmodule

`default_nettype wire

>>> rtl/record_field_layout.sv
// Path: input queue, layout stage register, output queue, then the result ports.
// Throughput: one member word per cycle while the output queue has room; the
//   running offset and bit position update (align, add, saturate) is combinational.
// Queues of two words at the input and the output decouple push and pop.
// Reset: synchronous, active low; clears both queues, the layout state and
//   union_mode. No clearing pass; the block accepts words right after reset.
// ---------------------------------------------------------------------------
// record_field_layout
// Lays out the members of a C record with bitfield packing, one member per
// word, returning byte/bit offsets and the record size on the last member.
// ---------------------------------------------------------------------------
`default_nettype none

module record_field_layout import rfl_pkg::*; #(
    parameter int OFFSET_BITS = 24
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [APB_DW-1:0]  pwdata,
    output logic      [APB_DW-1:0]  prdata,
    output logic                    pready,
    // member words
    input  wire logic               push,
    output logic                    full,
    input  wire logic [SIZE_W-1:0]  i_member_size,
    input  wire logic [ALIGN_W-1:0] i_member_align,
    input  wire logic [BITW_W-1:0]  i_bit_width,
    input  wire logic               i_is_named,
    input  wire logic               i_is_aggregate,
    input  wire logic               i_last_member,
    // result words
    output logic                    empty,
    input  wire logic               pop,
    output logic [OUT_OFS_W-1:0]    o_field_offset,
    output logic [BITOFF_W-1:0]     o_field_bit_offset,
    output logic [OUT_OFS_W-1:0]    o_record_size,
    output logic [ALIGN_W-1:0]      o_record_align,
    output logic                    o_record_done,
    output logic                    o_overflow
);

    localparam int RO_W = (OFFSET_BITS < OUT_OFS_W) ? OFFSET_BITS : OUT_OFS_W;

    logic    r_union_mode;
    logic    cfg_wr;
    t_item   front_item;
    t_item   q_item;
    logic    in_wr_ready, q_valid, q_ready;
    logic    res_valid;
    t_result res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_UNION_MODE);
    assign prdata = (paddr[2] == REG_UNION_MODE) ? {{(APB_DW-1){1'b0}}, r_union_mode} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_union_mode <= 1'b0;
        end else if (cfg_wr) begin
            r_union_mode <= pwdata[0];
        end
    end

    rfl_front u_front (
        .i_member_size  (i_member_size),
        .i_member_align (i_member_align),
        .i_bit_width    (i_bit_width),
        .i_is_named     (i_is_named),
        .i_is_aggregate (i_is_aggregate),
        .i_last_member  (i_last_member),
        .i_union_mode   (r_union_mode),
        .o_item         (front_item)
    );

    rfl_queue #(
        .T     (t_item),
        .DEPTH (2)
    ) u_in_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (push),
        .o_wr_ready (in_wr_ready),
        .i_wr_data  (front_item),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_data  (q_item)
    );

    assign full = !in_wr_ready;

    rfl_back #(
        .RO_W (RO_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (q_item),
        .i_item_valid (q_valid),
        .o_item_ready (q_ready),
        .o_res        (res),
        .o_res_valid  (res_valid),
        .i_res_ready  (pop)
    );

    assign empty              = !res_valid;
    assign o_field_offset     = res.field_offset;
    assign o_field_bit_offset = res.field_bit_offset;
    assign o_record_size      = res.record_size;
    assign o_record_align     = res.record_align;
    assign o_record_done      = res.record_done;
    assign o_overflow         = res.overflow;

endmodule

`default_nettype wire

>>> bench/tb.sv
// ---------------------------------------------------------------------------
// tb: record_field_layout testbench
// Drives member words through the push/full port and checks every result
// word against an in-bench layout predictor. Covers struct and union modes,
// bitfield packing, separators, offset saturation, random gaps and stalls,
// and one long result stall that backs the block up to full.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
    import rfl_pkg::*;

    localparam logic [2:0]      MODE_ADDR   = {REG_UNION_MODE, 2'b00};
    localparam longint unsigned OFS_LIMIT   = 64'hFF_FFFF;
    localparam int              HOLD_CYCLES = 300;
    localparam int              IDLE_LIMIT  = 4000;
    localparam int              MAX_REPORTS = 10;

    typedef struct packed {
        bit [SIZE_W-1:0]  size;
        bit [ALIGN_W-1:0] align;
        bit [BITW_W-1:0]  width;
        bit               named;
        bit               agg;
        bit               last;
    } t_member;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 psel           = 1'b0;
    logic                 penable        = 1'b0;
    logic                 pwrite         = 1'b0;
    logic [2:0]           paddr          = '0;
    logic [APB_DW-1:0]    pwdata         = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 push           = 1'b0;
    logic                 full;
    logic [SIZE_W-1:0]    i_member_size  = '0;
    logic [ALIGN_W-1:0]   i_member_align = '0;
    logic [BITW_W-1:0]    i_bit_width    = '0;
    logic                 i_is_named     = 1'b0;
    logic                 i_is_aggregate = 1'b0;
    logic                 i_last_member  = 1'b0;
    logic                 empty;
    logic                 pop            = 1'b0;
    logic [OUT_OFS_W-1:0] o_field_offset;
    logic [BITOFF_W-1:0]  o_field_bit_offset;
    logic [OUT_OFS_W-1:0] o_record_size;
    logic [ALIGN_W-1:0]   o_record_align;
    logic                 o_record_done;
    logic                 o_overflow;

    record_field_layout dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full),
        .i_member_size(i_member_size), .i_member_align(i_member_align),
        .i_bit_width(i_bit_width), .i_is_named(i_is_named),
        .i_is_aggregate(i_is_aggregate), .i_last_member(i_last_member),
        .empty(empty), .pop(pop),
        .o_field_offset(o_field_offset), .o_field_bit_offset(o_field_bit_offset),
        .o_record_size(o_record_size), .o_record_align(o_record_align),
        .o_record_done(o_record_done), .o_overflow(o_overflow)
    );

    always #6 i_clk = ~i_clk;

    // layout state mirrored from the block
    bit                   union_on;
    bit [OUT_OFS_W-1:0]   lay_ofs;
    bit [7:0]             lay_bit;
    bit [16:0]            lay_unit;
    bit [ALIGN_W-1:0]     lay_align;
    bit [OUT_OFS_W-1:0]   lay_big;
    bit                   lay_ovf;

    t_member  members_todo[$];
    t_result  layouts_due[$];
    t_member  next_member;
    t_member  taken_member;
    t_result  want;

    bit  rst_released = 1'b0;
    bit  member_taken = 1'b0;
    bit  send_gaps    = 1'b0;
    bit  take_stalls  = 1'b0;
    bit  hold_req     = 1'b0;
    int  send_wait    = 0;
    int  take_wait    = 0;
    int  hold_left    = 0;
    int  idle_cycles  = 0;
    int  mismatches   = 0;

    function automatic void clear_layout();
        lay_ofs   = '0;
        lay_bit   = '0;
        lay_unit  = '0;
        lay_align = 1;
        lay_big   = '0;
        lay_ovf   = 1'b0;
    endfunction

    function automatic bit [OUT_OFS_W-1:0] sat_offset(longint unsigned v);
        if (v > OFS_LIMIT) begin
            lay_ovf = 1'b1;
            return OFS_LIMIT[OUT_OFS_W-1:0];
        end
        return v[OUT_OFS_W-1:0];
    endfunction

    function automatic longint unsigned align_up(longint unsigned v, longint unsigned a);
        return (v + a - 1) & ~(a - 1);
    endfunction

    // zero counts as 1, clamp at 4096, round up to a power of two
    function automatic int unsigned fix_align(bit [ALIGN_W-1:0] a);
        int unsigned v;
        int unsigned p;
        v = (a == 0) ? 1 : a;
        if (v > ALIGN_MAX) v = ALIGN_MAX;
        p = 1;
        while (p < v) p = p << 1;
        return p;
    endfunction

    function automatic t_result place_member(t_member m);
        t_result         r;
        int unsigned     al;
        int unsigned     w;
        int unsigned     fit_bits;
        longint unsigned o;
        al = fix_align(m.align);
        w  = (m.width > BITW_MAX) ? BITW_MAX : m.width;
        r  = '0;
        if (al > lay_align) lay_align = ALIGN_W'(al);
        if (m.size > lay_big) lay_big = m.size;
        if (union_on) begin
            r.field_offset = '0;
        end else if (w > 0) begin
            if (lay_bit == 0) begin
                lay_ofs  = sat_offset(align_up(lay_ofs, al));
                lay_unit = m.size;
            end else if (m.size > lay_unit) begin
                lay_unit = m.size;
            end
            fit_bits = (lay_unit * 8 > 128) ? 128 : lay_unit * 8;
            // close the unit when the field does not fit
            if (lay_bit + w > fit_bits) begin
                lay_ofs  = sat_offset(align_up(lay_ofs + lay_unit, al));
                lay_bit  = '0;
                lay_unit = m.size;
            end
            r.field_offset     = lay_ofs;
            r.field_bit_offset = lay_bit[BITOFF_W-1:0];
            lay_bit = lay_bit + 8'(w);
        end else if (!m.named && !m.agg) begin
            if (lay_bit > 0) begin
                lay_ofs = sat_offset(lay_ofs + lay_unit);
                lay_bit = '0;
            end
            r.field_offset = lay_ofs;
        end else begin
            // advance only by the bytes the open bitfields used
            o = lay_ofs + (lay_bit + 7) / 8;
            lay_bit = '0;
            lay_ofs = sat_offset(align_up(o, al));
            r.field_offset = lay_ofs;
            lay_ofs = sat_offset(lay_ofs + m.size);
        end
        r.record_align = 1;
        r.record_done  = m.last;
        if (m.last) begin
            if (union_on)
                r.record_size = sat_offset(align_up(lay_big, lay_align));
            else
                r.record_size = sat_offset(align_up(lay_ofs + (lay_bit + 7) / 8, lay_align));
            r.record_align = lay_align;
        end
        r.overflow = lay_ovf;
        if (m.last) clear_layout();
        return r;
    endfunction

    function automatic int pick_gap(bit on);
        int unsigned r;
        if (!on) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_member random_member();
        t_member     m;
        int unsigned r;
        int unsigned k;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 4);
        m = '0;
        m.size  = 16'(1 << k);
        m.align = 13'(1 << $urandom_range(0, k));
        if (r < 40) begin
            m.width = 8'($urandom_range(1, m.size * 8));
            if ($urandom_range(0, 9) == 0) m.width = 8'($urandom_range(1, 128));
            m.named = ($urandom_range(0, 9) != 0);
        end else if (r < 75) begin
            m.named = 1'b1;
            m.agg   = ($urandom_range(0, 3) == 0);
            if (m.agg) begin
                m.size  = 16'($urandom_range(1, 64));
                m.align = 13'(1 << $urandom_range(0, 4));
            end
        end else if (r < 85) begin
            // unnamed zero-width separator: leave as is
        end else if (r < 95) begin
            m.agg  = 1'b1;
            m.size = 16'($urandom_range(0, 40));
        end else begin
            m.size  = 16'($urandom);
            m.align = 13'($urandom_range(0, 8191));
            m.width = 8'($urandom_range(0, 255));
            m.named = 1'($urandom_range(0, 1));
            m.agg   = 1'($urandom_range(0, 1));
        end
        return m;
    endfunction

    task automatic add_member(int size, int align, int width, bit named, bit agg, bit last);
        t_member m;
        m.size  = 16'(size);
        m.align = 13'(align);
        m.width = 8'(width);
        m.named = named;
        m.agg   = agg;
        m.last  = last;
        members_todo.push_back(m);
    endtask

    task automatic fill_records(int n);
        int      count;
        int      len;
        t_member m;
        count = 0;
        while (count < n) begin
            len = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 6) : $urandom_range(7, 16);
            for (int i = 0; i < len; i++) begin
                m = random_member();
                m.last = (i == len - 1);
                members_todo.push_back(m);
                count++;
            end
        end
    endtask

    task automatic flag_mismatch(string what, logic [63:0] expd, logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch %s: expected %0d, got %0d", what, expd, got);
    endtask

    task automatic check_field(string what, logic [63:0] expd, logic [63:0] got);
        if (got !== expd) flag_mismatch(what, expd, got);
    endtask

    // write union_mode, then read it back
    task automatic set_mode(bit v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODE_ADDR;
        pwdata  <= APB_DW'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        union_on = v;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        check_field("union_mode readback", v, prdata[0]);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        while (members_todo.size() > 0 || push || layouts_due.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // driver: offer the next member word, with random gaps
    always @(negedge i_clk) begin
        if (rst_released && (!push || member_taken)) begin
            if (send_wait > 0) begin
                send_wait--;
                push <= 1'b0;
            end else if (members_todo.size() > 0) begin
                next_member = members_todo.pop_front();
                i_member_size  <= next_member.size;
                i_member_align <= next_member.align;
                i_bit_width    <= next_member.width;
                i_is_named     <= next_member.named;
                i_is_aggregate <= next_member.agg;
                i_last_member  <= next_member.last;
                push <= 1'b1;
                send_wait = pick_gap(send_gaps);
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result side: long hold on request, else random stalls
    always @(negedge i_clk) begin
        if (rst_released) begin
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (take_wait > 0) begin
                take_wait--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                take_wait = pick_gap(take_stalls);
            end
        end
    end

    // monitor: check popped words, predict accepted ones
    always @(posedge i_clk) begin
        member_taken = push && !full;
        if (pop && !empty) begin
            if (layouts_due.size() == 0) begin
                flag_mismatch("result word with nothing pending", 0, o_field_offset);
            end else begin
                want = layouts_due.pop_front();
                check_field("field_offset", want.field_offset, o_field_offset);
                check_field("field_bit_offset", want.field_bit_offset, o_field_bit_offset);
                check_field("record_size", want.record_size, o_record_size);
                check_field("record_align", want.record_align, o_record_align);
                check_field("record_done", want.record_done, o_record_done);
                check_field("overflow", want.overflow, o_overflow);
            end
        end
        if (member_taken) begin
            taken_member.size  = i_member_size;
            taken_member.align = i_member_align;
            taken_member.width = i_bit_width;
            taken_member.named = i_is_named;
            taken_member.agg   = i_is_aggregate;
            taken_member.last  = i_last_member;
            layouts_due.push_back(place_member(taken_member));
        end
    end

    always @(posedge i_clk) begin
        if (rst_released) begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        union_on = 1'b0;
        clear_layout();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        rst_released = 1'b1;

        // struct packing corner cases
        set_mode(1'b0);
        add_member(1, 1, 0, 1, 0, 0);
        add_member(4, 4, 3, 1, 0, 0);
        add_member(4, 4, 5, 1, 0, 0);
        add_member(4, 4, 30, 1, 0, 0);
        add_member(2, 2, 0, 1, 0, 0);
        add_member(4, 4, 7, 1, 0, 0);
        add_member(4, 4, 0, 0, 0, 0);
        add_member(4, 4, 0, 0, 0, 0);
        add_member(16, 8, 128, 1, 0, 0);
        add_member(1, 1, 200, 1, 0, 0);
        add_member(8, 8, 0, 0, 1, 0);
        add_member(3, 0, 0, 1, 0, 0);
        add_member(5, 3, 0, 1, 0, 0);
        add_member(1, 8191, 0, 1, 0, 0);
        add_member(65535, 4096, 0, 1, 0, 0);
        add_member(0, 1, 1, 0, 0, 0);
        add_member(1, 1, 255, 0, 1, 0);
        add_member(0, 1, 0, 1, 0, 1);
        add_member(1, 1, 0, 1, 0, 1);
        drain();

        set_mode(1'b1);
        add_member(4, 4, 0, 1, 0, 0);
        add_member(8, 8, 3, 1, 0, 0);
        add_member(65535, 2, 0, 1, 0, 0);
        add_member(0, 1, 0, 0, 0, 1);
        drain();

        // switch mode in the middle of a record
        set_mode(1'b0);
        add_member(2, 2, 0, 1, 0, 0);
        add_member(4, 4, 9, 1, 0, 0);
        drain();
        set_mode(1'b1);
        add_member(8, 8, 0, 1, 0, 0);
        add_member(1, 1, 0, 1, 0, 1);
        drain();

        // push offsets past the 24-bit range
        set_mode(1'b0);
        send_gaps   = 1'b1;
        take_stalls = 1'b1;
        for (int i = 0; i < 260; i++) begin
            if (i == 258) add_member(4, 4, 5, 1, 0, 0);
            else add_member(65535, 4096, 0, 1, 0, i == 259);
        end
        drain();

        for (int phase = 0; phase < 7; phase++) begin
            set_mode(phase == 0 ? 1'b0 : phase == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
            send_gaps   = (phase % 3 != 2);
            take_stalls = (phase % 3 != 1);
            if (phase == 3) hold_req = 1'b1;
            fill_records(130);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/rfl_pkg.sv
rtl/rfl_front.sv
rtl/rfl_queue.sv
rtl/rfl_back.sv
rtl/record_field_layout.sv
bench/tb.sv
